[hdl/ccs_pkg.sv]
package ccs_pkg;

	localparam int OP_W     = 3;
	localparam int LINE_W   = 6;
	localparam int HANDLE_W = 10;
	localparam int CODE_W   = 4;
	localparam int STATE_W  = 3;

	// event codes
	localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
	localparam logic [OP_W-1:0] OP_PICKUP     = 3'd2;
	localparam logic [OP_W-1:0] OP_DIAL       = 3'd3;
	localparam logic [OP_W-1:0] OP_HANGUP     = 3'd4;
	localparam logic [OP_W-1:0] OP_CHAT       = 3'd5;

	// line states, same values as the matching message codes
	localparam logic [STATE_W-1:0] ST_ONHOOK    = 3'd0;
	localparam logic [STATE_W-1:0] ST_RINGING   = 3'd1;
	localparam logic [STATE_W-1:0] ST_DIALTONE  = 3'd2;
	localparam logic [STATE_W-1:0] ST_RINGBACK  = 3'd3;
	localparam logic [STATE_W-1:0] ST_BUSY      = 3'd4;
	localparam logic [STATE_W-1:0] ST_CONNECTED = 3'd5;
	localparam logic [STATE_W-1:0] ST_ERROR     = 3'd6;

	localparam logic [CODE_W-1:0] MSG_ONHOOK    = 4'd0;
	localparam logic [CODE_W-1:0] MSG_RINGING   = 4'd1;
	localparam logic [CODE_W-1:0] MSG_DIALTONE  = 4'd2;
	localparam logic [CODE_W-1:0] MSG_RINGBACK  = 4'd3;
	localparam logic [CODE_W-1:0] MSG_BUSY      = 4'd4;
	localparam logic [CODE_W-1:0] MSG_CONNECTED = 4'd5;
	localparam logic [CODE_W-1:0] MSG_ERROR     = 4'd6;
	localparam logic [CODE_W-1:0] MSG_CHAT      = 4'd7;
	localparam logic [CODE_W-1:0] MSG_REJECT    = 4'd8;

	typedef struct packed {
		logic [LINE_W-1:0] dest;
		logic [CODE_W-1:0] code;
		logic [LINE_W-1:0] arg;
	} note_t;

	function automatic note_t mk_note(logic [LINE_W-1:0] dest, logic [CODE_W-1:0] code,
			logic [LINE_W-1:0] arg);
		note_t n;
		n.dest = dest;
		n.code = code;
		n.arg  = arg;
		return n;
	endfunction

endpackage

[hdl/call_control_switch_unit.sv]
// Call control switch over a table of NUM_LINES lines kept in one synchronous RAM
// (one read, one write port). start is taken when busy is low; each notification
// appears for exactly one cycle with valid high, and the receiver cannot stall it,
// so it must take every beat. An event on a line reads the peer, reads the dialled
// line, decides, then runs the write-back states WB1 and WB2 that also carry the
// notifications; the line itself is read in the accepting cycle. An event on a
// line not in use skips the dialled-line read and the decision; a rejected op or
// out-of-range unit goes straight to write-back. A register turns the handle into
// its home slot (reciprocal multiply at acceptance, multiply back and subtract
// after), reads and checks probed slots one after another, then writes back, all
// bound by the single RAM read port; into a full table it skips the probe. After
// reset the block clears the in-use bits, one RAM write per cycle, busy until done.
module call_control_switch_unit
	import ccs_pkg::*;
#(
	parameter int NUM_LINES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     op,
	input  logic [LINE_W-1:0]   unit,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [LINE_W-1:0]   dial_number,
	output logic                valid,
	output logic [LINE_W-1:0]   dest_line,
	output logic [CODE_W-1:0]   msg_code,
	output logic [LINE_W-1:0]   arg_line,
	output logic                last
);

	localparam int LW = $clog2(NUM_LINES);
	localparam int OW = $clog2(NUM_LINES + 1);
	// rounded-up reciprocal of NUM_LINES, exact quotient for every handle
	localparam int MOD_SH  = HANDLE_W + $clog2(NUM_LINES);
	localparam int MOD_MUL = ((1 << MOD_SH) + NUM_LINES - 1) / NUM_LINES;
	localparam int PW      = 2 * HANDLE_W + 2;
	localparam int RW      = HANDLE_W + LW + 1;

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_MOD      = 4'd2;
	localparam logic [3:0] S_PROBE_RD = 4'd3;
	localparam logic [3:0] S_PROBE_CK = 4'd4;
	localparam logic [3:0] S_RD_P     = 4'd5;
	localparam logic [3:0] S_RD_X     = 4'd6;
	localparam logic [3:0] S_EXEC     = 4'd7;
	localparam logic [3:0] S_WB1      = 4'd8;
	localparam logic [3:0] S_WB2      = 4'd9;

	typedef struct packed {
		logic                used;
		logic [STATE_W-1:0]  st;
		logic [LW-1:0]       peer;
	} entry_t;

	function automatic logic [LINE_W-1:0] to_line(logic [LW-1:0] x);
		logic [LW+LINE_W-1:0] t;
		t = {{LINE_W{1'b0}}, x};
		return t[LINE_W-1:0];
	endfunction

	function automatic logic [LW-1:0] to_idx(logic [LINE_W-1:0] x);
		logic [LW+LINE_W-1:0] t;
		t = {{LW{1'b0}}, x};
		return t[LW-1:0];
	endfunction

	function automatic entry_t mk_entry(logic [STATE_W-1:0] s, logic [LW-1:0] pr);
		entry_t e;
		e.used = 1'b1;
		e.st   = s;
		e.peer = pr;
		return e;
	endfunction

	function automatic note_t report(logic [LW-1:0] u, entry_t e);
		note_t n;
		case (e.st)
			ST_ONHOOK:    n = mk_note(to_line(u), MSG_ONHOOK, to_line(u));
			ST_CONNECTED: n = mk_note(to_line(u), MSG_CONNECTED, to_line(e.peer));
			ST_ERROR, ST_RINGING, ST_DIALTONE, ST_RINGBACK, ST_BUSY:
				n = mk_note(to_line(u), {1'b0, e.st}, '0);
			default:      n = mk_note(to_line(u), MSG_ERROR, '0);
		endcase
		return n;
	endfunction

	entry_t mem [NUM_LINES];
	entry_t rdata;
	logic           mem_we;
	logic [LW-1:0]  mem_waddr;
	entry_t         mem_wdata;
	logic           mem_re;
	logic [LW-1:0]  mem_raddr;

	logic [3:0]          state_q;
	logic [LW-1:0]       clr_q;
	logic [OW-1:0]       occ_q;
	logic [OP_W-1:0]     op_q;
	logic [LW-1:0]       unit_q;
	logic [LINE_W-1:0]   ext_q;
	logic [HANDLE_W-1:0] rem_q;
	logic [HANDLE_W-1:0] quot_q;
	logic [LW-1:0]       slot_q;
	entry_t              ue_q;
	logic                pv_q;

	logic          w1_en_q, w2_en_q;
	logic [LW-1:0] w1_addr_q, w2_addr_q;
	entry_t        w1_data_q, w2_data_q;
	logic [1:0]    n_cnt_q;
	note_t         n1_q, n2_q;

	// decision for one line event
	logic          p_w1_en, p_w2_en;
	logic [LW-1:0] p_w1_addr, p_w2_addr;
	entry_t        p_w1_data, p_w2_data;
	logic [1:0]    p_cnt;
	note_t         p_n1, p_n2;

	logic [PW-1:0]       mod_prod;
	logic [PW-1:0]       mod_quot;
	logic [RW-1:0]       mod_back;
	logic [RW-1:0]       mod_rem;
	logic [LW-1:0]       rem_slot;
	logic [LW-1:0]       slot_next;
	logic [LW-1:0]       ext_idx;
	logic                ext_ok;
	logic                unit_ok;
	logic                op_ok;
	note_t               out_note;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata <= mem[mem_raddr];
	end

	assign busy    = (state_q != S_IDLE);
	assign unit_ok = (32'(unit) < NUM_LINES);
	assign op_ok   = (op <= OP_CHAT);
	assign ext_idx = to_idx(ext_q);
	assign ext_ok  = (32'(ext_q) < NUM_LINES) && rdata.used;

	// quotient at acceptance, remainder in the following cycle
	assign mod_prod = PW'(handle) * PW'(MOD_MUL);
	assign mod_quot = mod_prod >> MOD_SH;
	assign mod_back = RW'(quot_q) * RW'(NUM_LINES);
	assign mod_rem  = RW'(rem_q) - mod_back;
	assign rem_slot = mod_rem[LW-1:0];

	assign slot_next = (32'(slot_q) + 1 == NUM_LINES) ? '0 : slot_q + 1'b1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = w1_addr_q;
		mem_wdata = w1_data_q;
		mem_re    = 1'b0;
		mem_raddr = to_idx(unit);
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_re    = start && unit_ok;
				mem_raddr = to_idx(unit);
			end
			S_PROBE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = slot_q;
			end
			S_RD_P: begin
				mem_re    = 1'b1;
				mem_raddr = rdata.peer;
			end
			S_RD_X: begin
				mem_re    = 1'b1;
				mem_raddr = ext_idx;
			end
			S_WB1: begin
				mem_we    = w1_en_q;
				mem_waddr = w1_addr_q;
				mem_wdata = w1_data_q;
			end
			S_WB2: begin
				mem_we    = w2_en_q;
				mem_waddr = w2_addr_q;
				mem_wdata = w2_data_q;
			end
			default: begin
				mem_we = 1'b0;
				mem_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		logic [STATE_W-1:0] st;
		logic [LW-1:0]      p;
		st        = ue_q.st;
		p         = ue_q.peer;
		p_w1_en   = 1'b0;
		p_w1_addr = unit_q;
		p_w1_data = '0;
		p_w2_en   = 1'b0;
		p_w2_addr = unit_q;
		p_w2_data = '0;
		p_cnt     = 2'd0;
		p_n1      = '0;
		p_n2      = '0;
		case (op_q)
			OP_UNREGISTER: begin
				if (pv_q && (st inside {ST_CONNECTED, ST_RINGING})) begin
					p_w1_en   = 1'b1;
					p_w1_addr = p;
					p_w1_data = mk_entry(ST_DIALTONE, p);
					p_n1      = mk_note(to_line(p), MSG_DIALTONE, '0);
					p_cnt     = 2'd1;
				end else if (pv_q && st == ST_RINGBACK) begin
					p_w1_en   = 1'b1;
					p_w1_addr = p;
					p_w1_data = mk_entry(ST_ONHOOK, p);
					p_n1      = mk_note(to_line(p), MSG_ONHOOK, to_line(p));
					p_cnt     = 2'd1;
				end
				// free the slot after the peer update
				p_w2_en   = 1'b1;
				p_w2_addr = unit_q;
				p_w2_data = '0;
			end
			OP_PICKUP: begin
				p_cnt = 2'd1;
				if (st == ST_ONHOOK) begin
					p_w1_en   = 1'b1;
					p_w1_data = mk_entry(ST_DIALTONE, p);
					p_n1      = mk_note(to_line(unit_q), MSG_DIALTONE, '0);
				end else if (st == ST_RINGING && pv_q) begin
					p_w1_en   = 1'b1;
					p_w1_data = mk_entry(ST_CONNECTED, p);
					p_n1      = mk_note(to_line(unit_q), MSG_CONNECTED, to_line(p));
					p_w2_en   = 1'b1;
					p_w2_addr = p;
					p_w2_data = mk_entry(ST_CONNECTED, unit_q);
					p_n2      = mk_note(to_line(p), MSG_CONNECTED, to_line(unit_q));
					p_cnt     = 2'd2;
				end else begin
					p_n1 = report(unit_q, ue_q);
				end
			end
			OP_DIAL: begin
				p_cnt = 2'd1;
				if (st != ST_DIALTONE) begin
					p_n1 = report(unit_q, ue_q);
				end else if (!ext_ok) begin
					p_w1_en   = 1'b1;
					p_w1_data = mk_entry(ST_ERROR, p);
					p_n1      = mk_note(to_line(unit_q), MSG_ERROR, '0);
				end else if (rdata.st == ST_ONHOOK && ext_idx != unit_q) begin
					p_w1_en   = 1'b1;
					p_w1_data = mk_entry(ST_RINGBACK, ext_idx);
					p_n1      = mk_note(to_line(unit_q), MSG_RINGBACK, '0);
					p_w2_en   = 1'b1;
					p_w2_addr = ext_idx;
					p_w2_data = mk_entry(ST_RINGING, unit_q);
					p_n2      = mk_note(ext_q, MSG_RINGING, '0);
					p_cnt     = 2'd2;
				end else begin
					p_w1_en   = 1'b1;
					p_w1_data = mk_entry(ST_BUSY, p);
					p_n1      = mk_note(to_line(unit_q), MSG_BUSY, '0);
				end
			end
			OP_HANGUP: begin
				p_w1_en   = 1'b1;
				p_w1_data = mk_entry(ST_ONHOOK, unit_q);
				p_n1      = mk_note(to_line(unit_q), MSG_ONHOOK, to_line(unit_q));
				p_cnt     = 2'd1;
				if (st != ST_ONHOOK && pv_q && p != unit_q) begin
					if (st inside {ST_CONNECTED, ST_RINGING}) begin
						p_w2_en   = 1'b1;
						p_w2_addr = p;
						p_w2_data = mk_entry(ST_DIALTONE, p);
						p_n2      = mk_note(to_line(p), MSG_DIALTONE, '0);
						p_cnt     = 2'd2;
					end else if (st == ST_RINGBACK) begin
						p_w2_en   = 1'b1;
						p_w2_addr = p;
						p_w2_data = mk_entry(ST_ONHOOK, p);
						p_n2      = mk_note(to_line(p), MSG_ONHOOK, to_line(p));
						p_cnt     = 2'd2;
					end
				end
			end
			OP_CHAT: begin
				p_cnt = 2'd1;
				if (st == ST_CONNECTED) begin
					if (pv_q) begin
						p_n1  = mk_note(to_line(p), MSG_CHAT, '0);
						p_n2  = mk_note(to_line(unit_q), MSG_CONNECTED, to_line(p));
						p_cnt = 2'd2;
					end else begin
						p_n1 = mk_note(to_line(unit_q), MSG_CONNECTED, to_line(p));
					end
				end else begin
					p_n1 = report(unit_q, ue_q);
				end
			end
			default: begin
				p_cnt = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			occ_q   <= '0;
			n_cnt_q <= 2'd0;
			w1_en_q <= 1'b0;
			w2_en_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NUM_LINES - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						unit_q  <= to_idx(unit);
						ext_q   <= dial_number;
						rem_q   <= handle;
						quot_q  <= mod_quot[HANDLE_W-1:0];
						w1_en_q <= 1'b0;
						w2_en_q <= 1'b0;
						if (op == OP_REGISTER) begin
							state_q <= S_MOD;
						end else if (!op_ok || !unit_ok) begin
							n1_q    <= mk_note(unit, MSG_REJECT, '0);
							n_cnt_q <= 2'd1;
							state_q <= S_WB1;
						end else begin
							state_q <= S_RD_P;
						end
					end
				end
				S_MOD: begin
					slot_q <= rem_slot;
					if (32'(occ_q) >= NUM_LINES) begin
						n1_q    <= mk_note(to_line(rem_slot), MSG_REJECT, '0);
						n_cnt_q <= 2'd1;
						state_q <= S_WB1;
					end else begin
						state_q <= S_PROBE_RD;
					end
				end
				S_PROBE_RD: begin
					state_q <= S_PROBE_CK;
				end
				S_PROBE_CK: begin
					if (rdata.used) begin
						slot_q  <= slot_next;
						state_q <= S_PROBE_RD;
					end else begin
						w1_en_q   <= 1'b1;
						w1_addr_q <= slot_q;
						w1_data_q <= mk_entry(ST_ONHOOK, slot_q);
						n1_q      <= mk_note(to_line(slot_q), MSG_ONHOOK, to_line(slot_q));
						n_cnt_q   <= 2'd1;
						occ_q     <= occ_q + 1'b1;
						state_q   <= S_WB1;
					end
				end
				S_RD_P: begin
					ue_q <= rdata;
					if (!rdata.used) begin
						n1_q    <= mk_note(to_line(unit_q), MSG_REJECT, '0);
						n_cnt_q <= 2'd1;
						state_q <= S_WB1;
					end else begin
						state_q <= S_RD_X;
					end
				end
				S_RD_X: begin
					pv_q    <= (32'(ue_q.peer) < NUM_LINES) && rdata.used;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					w1_en_q   <= p_w1_en;
					w1_addr_q <= p_w1_addr;
					w1_data_q <= p_w1_data;
					w2_en_q   <= p_w2_en;
					w2_addr_q <= p_w2_addr;
					w2_data_q <= p_w2_data;
					n1_q      <= p_n1;
					n2_q      <= p_n2;
					n_cnt_q   <= p_cnt;
					if (op_q == OP_UNREGISTER && occ_q != '0)
						occ_q <= occ_q - 1'b1;
					state_q   <= S_WB1;
				end
				S_WB1: begin
					state_q <= S_WB2;
				end
				S_WB2: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// at most one notification beat per write-back cycle
	assign out_note  = (state_q == S_WB2) ? n2_q : n1_q;
	assign valid     = ((state_q == S_WB1) && (n_cnt_q != 2'd0)) ||
	                   ((state_q == S_WB2) && (n_cnt_q == 2'd2));
	assign last      = (state_q == S_WB2) || (n_cnt_q == 2'd1);
	assign dest_line = out_note.dest;
	assign msg_code  = out_note.code;
	assign arg_line  = out_note.arg;

endmodule

[tb/call_control_switch_unit_test.sv]
module call_control_switch_unit_test
	import ccs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINES = 64;
	localparam int ANY_STATE = -1;
	localparam int DRAIN_CYCLES = 200;

	// event codes the block does not know
	localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

	typedef struct packed {
		note_t note;
		logic  last;
	} due_note_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [OP_W-1:0]     op = '0;
	logic [LINE_W-1:0]   unit = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic [LINE_W-1:0]   dial_number = '0;
	logic                valid;
	logic [LINE_W-1:0]   dest_line;
	logic [CODE_W-1:0]   msg_code;
	logic [LINE_W-1:0]   arg_line;
	logic                last;

	// shadow of the line table
	logic               used_map [LINES];
	logic [STATE_W-1:0] call_state [LINES];
	logic [LINE_W-1:0]  peer_of [LINES];
	int                 lines_taken = 0;

	due_note_t notes_due [$];
	due_note_t staged [2];
	int        staged_n;
	int        mismatches = 0;
	int        gap_pct = 15;

	call_control_switch_unit #(.NUM_LINES(LINES)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.unit        (unit),
		.handle      (handle),
		.dial_number (dial_number),
		.valid       (valid),
		.dest_line   (dest_line),
		.msg_code    (msg_code),
		.arg_line    (arg_line),
		.last        (last)
	);

	always #2 clk = ~clk;

	function automatic void stage_note(logic [LINE_W-1:0] d, logic [CODE_W-1:0] c,
			logic [LINE_W-1:0] a);
		staged[staged_n].note.dest = d;
		staged[staged_n].note.code = c;
		staged[staged_n].note.arg  = a;
		staged[staged_n].last      = 1'b0;
		staged_n++;
	endfunction

	function automatic void move_line(logic [LINE_W-1:0] l, logic [STATE_W-1:0] st,
			logic [LINE_W-1:0] p);
		call_state[l] = st;
		peer_of[l]    = p;
	endfunction

	// tell a line its current state again
	function automatic void restate_line(logic [LINE_W-1:0] l);
		logic [STATE_W-1:0] st;
		st = call_state[l];
		if (st == ST_ONHOOK)
			stage_note(l, MSG_ONHOOK, l);
		else if (st == ST_CONNECTED)
			stage_note(l, MSG_CONNECTED, peer_of[l]);
		else if (st > ST_ERROR)
			stage_note(l, MSG_ERROR, '0);
		else
			stage_note(l, CODE_W'(st), '0);
	endfunction

	function automatic void predict_switch_event(logic [OP_W-1:0] o, logic [LINE_W-1:0] u,
			logic [HANDLE_W-1:0] h, logic [LINE_W-1:0] x);
		logic [LINE_W-1:0]  slot;
		logic [LINE_W-1:0]  p;
		logic [STATE_W-1:0] st;
		logic               pv;
		staged_n = 0;
		if (o == OP_REGISTER) begin
			slot = LINE_W'(h % LINES);
			if (lines_taken >= LINES) begin
				stage_note(slot, MSG_REJECT, '0);
			end else begin
				for (int n = 0; n < LINES && used_map[slot]; n++)
					slot = slot + 1'b1;
				used_map[slot] = 1'b1;
				move_line(slot, ST_ONHOOK, slot);
				lines_taken++;
				stage_note(slot, MSG_ONHOOK, slot);
			end
		end else if (o > OP_CHAT || !used_map[u]) begin
			stage_note(u, MSG_REJECT, '0);
		end else begin
			st = call_state[u];
			p  = peer_of[u];
			pv = used_map[p];
			case (o)
				OP_UNREGISTER: begin
					if (pv && (st == ST_CONNECTED || st == ST_RINGING)) begin
						move_line(p, ST_DIALTONE, p);
						stage_note(p, MSG_DIALTONE, '0);
					end else if (pv && st == ST_RINGBACK) begin
						move_line(p, ST_ONHOOK, p);
						stage_note(p, MSG_ONHOOK, p);
					end
					used_map[u] = 1'b0;
					if (lines_taken > 0)
						lines_taken--;
				end
				OP_PICKUP: begin
					if (st == ST_ONHOOK) begin
						move_line(u, ST_DIALTONE, p);
						stage_note(u, MSG_DIALTONE, '0);
					end else if (st == ST_RINGING && pv) begin
						move_line(u, ST_CONNECTED, p);
						stage_note(u, MSG_CONNECTED, p);
						move_line(p, ST_CONNECTED, u);
						stage_note(p, MSG_CONNECTED, u);
					end else begin
						restate_line(u);
					end
				end
				OP_DIAL: begin
					if (st != ST_DIALTONE) begin
						restate_line(u);
					end else if (!used_map[x]) begin
						move_line(u, ST_ERROR, p);
						stage_note(u, MSG_ERROR, '0);
					end else if (call_state[x] == ST_ONHOOK && x != u) begin
						move_line(u, ST_RINGBACK, x);
						stage_note(u, MSG_RINGBACK, '0);
						move_line(x, ST_RINGING, u);
						stage_note(x, MSG_RINGING, '0);
					end else begin
						move_line(u, ST_BUSY, p);
						stage_note(u, MSG_BUSY, '0);
					end
				end
				OP_HANGUP: begin
					move_line(u, ST_ONHOOK, u);
					stage_note(u, MSG_ONHOOK, u);
					if (st != ST_ONHOOK && pv && p != u) begin
						if (st == ST_CONNECTED || st == ST_RINGING) begin
							move_line(p, ST_DIALTONE, p);
							stage_note(p, MSG_DIALTONE, '0);
						end else if (st == ST_RINGBACK) begin
							move_line(p, ST_ONHOOK, p);
							stage_note(p, MSG_ONHOOK, p);
						end
					end
				end
				default: begin
					if (st == ST_CONNECTED) begin
						if (pv)
							stage_note(p, MSG_CHAT, '0);
						stage_note(u, MSG_CONNECTED, p);
					end else begin
						restate_line(u);
					end
				end
			endcase
		end
		for (int i = 0; i < staged_n; i++) begin
			staged[i].last = (i == staged_n - 1);
			notes_due.push_back(staged[i]);
		end
	endfunction

	function automatic logic [LINE_W-1:0] pick_line(int want);
		int cands [$];
		for (int i = 0; i < LINES; i++)
			if (used_map[i] && (want < 0 || call_state[i] == want))
				cands.push_back(i);
		if (cands.size() == 0)
			return LINE_W'($urandom_range(LINES - 1));
		return LINE_W'(cands[$urandom_range(cands.size() - 1)]);
	endfunction

	function automatic void log_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endfunction

	task automatic place_event(input logic [OP_W-1:0] o, input logic [LINE_W-1:0] u,
			input logic [HANDLE_W-1:0] h, input logic [LINE_W-1:0] x);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		op          <= o;
		unit        <= u;
		handle      <= h;
		dial_number <= x;
		do @(posedge clk); while (busy !== 1'b0);
		predict_switch_event(o, u, h, x);
	endtask

	always @(posedge clk) begin
		due_note_t want;
		if (valid === 1'b1) begin
			if (notes_due.size() == 0) begin
				log_mismatch($sformatf("unexpected beat dest %0d code %0d arg %0d last %0b",
					dest_line, msg_code, arg_line, last));
			end else begin
				want = notes_due.pop_front();
				if (dest_line !== want.note.dest || msg_code !== want.note.code ||
						arg_line !== want.note.arg || last !== want.last)
					log_mismatch($sformatf(
						"dest %0d/%0d code %0d/%0d arg %0d/%0d last %0b/%0b (exp/act)",
						want.note.dest, dest_line, want.note.code, msg_code,
						want.note.arg, arg_line, want.last, last));
			end
		end
	end

	task automatic test_directed_calls();
		place_event(OP_CHAT, 6'd0, '0, '0);         // line not in use
		place_event(OP_BAD_LO, 6'd63, '0, '0);
		place_event(OP_BAD_HI, 6'd21, 10'h2aa, 6'h2a);
		place_event(OP_REGISTER, 6'd5, 10'd1023, '0);
		place_event(OP_REGISTER, 6'd0, 10'd0, '0);
		place_event(OP_REGISTER, 6'd0, 10'd64, '0);   // probes past one used slot
		place_event(OP_REGISTER, 6'd0, 10'd63, '0);   // probe wraps past the top
		place_event(OP_PICKUP, 6'd0, '0, '0);
		place_event(OP_DIAL, 6'd0, '0, 6'd63);
		place_event(OP_CHAT, 6'd63, '0, '0);
		place_event(OP_PICKUP, 6'd63, '0, '0);
		place_event(OP_CHAT, 6'd0, '0, '0);
		place_event(OP_HANGUP, 6'd63, '0, '0);
		place_event(OP_DIAL, 6'd0, '0, 6'd0);        // dial to itself
		place_event(OP_HANGUP, 6'd0, '0, '0);
		place_event(OP_HANGUP, 6'd0, '0, '0);
		place_event(OP_PICKUP, 6'd1, '0, '0);
		place_event(OP_DIAL, 6'd1, '0, 6'd40);       // extension not in use
		place_event(OP_PICKUP, 6'd1, '0, '0);
		place_event(OP_HANGUP, 6'd1, '0, '0);
		place_event(OP_PICKUP, 6'd2, '0, '0);
		place_event(OP_DIAL, 6'd2, '0, 6'd1);
		place_event(OP_UNREGISTER, 6'd2, '0, '0);    // caller leaves during ring back
		place_event(OP_DIAL, 6'd63, '0, 6'd1);       // not at dial tone
		place_event(OP_UNREGISTER, 6'd63, '0, '0);   // no beat at all
	endtask

	task automatic test_table_full();
		while (lines_taken < LINES)
			place_event(OP_REGISTER, LINE_W'($urandom), HANDLE_W'($urandom), '0);
		place_event(OP_REGISTER, '0, 10'd1023, '0);
		place_event(OP_REGISTER, '0, HANDLE_W'($urandom), '0);
		place_event(OP_PICKUP, 6'd17, '0, '0);
		place_event(OP_DIAL, 6'd17, '0, 6'd48);
		place_event(OP_PICKUP, 6'd48, '0, '0);
		for (int i = 0; i < LINES; i++)
			place_event(OP_UNREGISTER, LINE_W'(i), '0, '0);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count);
		logic [OP_W-1:0]   o;
		logic [LINE_W-1:0] u;
		logic [LINE_W-1:0] x;
		int                r;
		gap_pct = idle_pct;
		repeat (count) begin
			r = $urandom_range(99);
			if (lines_taken < 3 || r < 10)
				o = OP_REGISTER;
			else if (r < 17 || (lines_taken > 24 && r < 30))
				o = OP_UNREGISTER;
			else if (r < 37)
				o = OP_PICKUP;
			else if (r < 62)
				o = OP_DIAL;
			else if (r < 76)
				o = OP_HANGUP;
			else if (r < 94)
				o = OP_CHAT;
			else
				o = OP_W'($urandom_range(7));
			// steer most events to lines in the state where they do something
			if ($urandom_range(9) == 0)
				u = LINE_W'($urandom_range(LINES - 1));
			else case (o)
				OP_DIAL:   u = pick_line($urandom_range(9) < 7 ? ST_DIALTONE : ANY_STATE);
				OP_PICKUP: u = pick_line($urandom_range(9) < 5 ? ST_RINGING : ANY_STATE);
				OP_CHAT:   u = pick_line($urandom_range(9) < 6 ? ST_CONNECTED : ANY_STATE);
				default:   u = pick_line(ANY_STATE);
			endcase
			r = $urandom_range(9);
			if (r < 5)
				x = pick_line(ST_ONHOOK);
			else if (r < 8)
				x = pick_line(ANY_STATE);
			else
				x = LINE_W'($urandom_range(LINES - 1));
			place_event(o, u, HANDLE_W'($urandom_range(1023)), x);
		end
	endtask

	initial begin
		for (int i = 0; i < LINES; i++)
			used_map[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct = 15;
		test_directed_calls();
		test_table_full();
		test_random_traffic(15, 230);
		test_random_traffic(67, 230);
		test_random_traffic(0, 230);
		start <= 1'b0;
		while (notes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && notes_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
